[src/qpf_pkg.sv]
// ----------------------------------------------------------------------------
// qpf_pkg: shared types and constants for the QRS preprocessing filter chain
// Register indexes, memory map of the history store and divider control.
// ----------------------------------------------------------------------------
package qpf_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_DIVISOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b1;

    localparam int CFG_DATA_W = 8;
    localparam int SAMPLE_W   = 16;
    localparam int STAGE_W    = 24;
    localparam int SQUARE_W   = 46;

    // history store: low-pass ring in the lower half, input ring at the start of the upper half
    localparam int HIST_AW    = 7;
    localparam int HIST_DEPTH = 128;
    localparam int LP_AW      = 6;
    localparam int X_AW       = 4;
    localparam logic [HIST_AW-X_AW-1:0] X_BASE = 3'b100;

    localparam int DIV_CNT_W  = 6;
    localparam int DIVISOR_W  = 8;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIVISOR_W-1:0] divisor;
    } div_ctl_t;

endpackage

[src/qpf_ram.sv]
// ----------------------------------------------------------------------------
// qpf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/qpf_div.sv]
// ----------------------------------------------------------------------------
// qpf_div: restoring unsigned divider, one quotient bit per cycle
// Dividend is left-aligned by the caller; iters sets the number of steps.
// ----------------------------------------------------------------------------
module qpf_div #(
    parameter int DW = 51
) (
    input  logic               clk,
    input  logic               rst_n,
    input  qpf_pkg::div_ctl_t  ctl,
    input  logic [DW-1:0]      dividend,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    logic [DW-1:0]                  q_reg;
    logic [qpf_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [qpf_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [qpf_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [qpf_pkg::DIVISOR_W:0]    shifted;
    logic                           ge;

    assign shifted = {rem_reg, q_reg[DW-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == qpf_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= ctl.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], ge};
            rem_reg <= ge ? qpf_pkg::DIVISOR_W'(shifted - {1'b0, dsr_reg})
                          : shifted[qpf_pkg::DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[src/qrs_preprocess_filter_chain_core.sv]
// ----------------------------------------------------------------------------
// qrs_preprocess_filter_chain_core: five-stage QRS preprocessing chain
// Each word runs through the bit-serial divider: three 24-step divisions
// and one window average division. A window_length change makes the next
// word re-sum its whole window from the square memory. One word at a time;
// the result register frees the input.
// After reset a clearing pass zeroes both memories; no input word is taken
// during it.
// ----------------------------------------------------------------------------
module qrs_preprocess_filter_chain_core #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [qpf_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [qpf_pkg::SAMPLE_W-1:0]   sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [qpf_pkg::STAGE_W-1:0]    lowpass_out,
    output logic signed [qpf_pkg::STAGE_W-1:0]    highpass_out,
    output logic signed [qpf_pkg::STAGE_W-1:0]    derivative_out,
    output logic [qpf_pkg::SQUARE_W-1:0]          squared_out,
    output logic [qpf_pkg::SQUARE_W-1:0]          integrated_out
);

    localparam int SQ_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WIN_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = qpf_pkg::SQUARE_W + $clog2(WINDOW_DEPTH);
    localparam int SW    = qpf_pkg::STAGE_W;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_READ    = 14'b00000000000100,
        S_DIV_LP  = 14'b00000000001000,
        S_LP      = 14'b00000000010000,
        S_DIV_Y0  = 14'b00000000100000,
        S_DIV_Y32 = 14'b00000001000000,
        S_DER     = 14'b00000010000000,
        S_MUL     = 14'b00000100000000,
        S_ACC     = 14'b00001000000000,
        S_SUM     = 14'b00010000000000,
        S_AVG_GO  = 14'b00100000000000,
        S_AVG     = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    function automatic logic signed [27:0] sx24(input logic [SW-1:0] v);
        return {{4{v[SW-1]}}, v};
    endfunction

    function automatic logic [SW-1:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607)
        begin
            return 24'h7FFFFF;
        end
        else if (v < -28'sd8388608)
        begin
            return 24'h800000;
        end
        return v[SW-1:0];
    endfunction

    state_t                          state_reg;
    state_t                          state_next;
    logic [qpf_pkg::HIST_AW-1:0]     clr_reg;
    logic [2:0]                      cnt_reg;
    logic [qpf_pkg::LP_AW-1:0]       n_reg;
    logic [SQ_AW-1:0]                ptr_reg;
    logic [SQ_AW-1:0]                raddr_reg;
    logic [WIN_W-1:0]                rc_reg;
    logic                            pend_reg;
    logic                            dirty_reg;
    logic [7:0]                      divisor_reg;
    logic [5:0]                      wlen_reg;

    logic signed [15:0]              x0_reg;
    logic signed [15:0]              x6_reg;
    logic signed [15:0]              x12_reg;
    logic [SW-1:0]                   y1_reg;
    logic [SW-1:0]                   y2_reg;
    logic [SW-1:0]                   y16_reg;
    logic [SW-1:0]                   y17_reg;
    logic [SW-1:0]                   y32_reg;
    logic [SW-1:0]                   lp_reg;
    logic [SW-1:0]                   hp_reg;
    logic [SW-1:0]                   h1_reg;
    logic [SW-1:0]                   h2_reg;
    logic [SW-1:0]                   h3_reg;
    logic [SW-1:0]                   h4_reg;
    logic signed [SW-1:0]            d_reg;
    logic signed [24:0]              q2_reg;
    logic                            neg_reg;
    logic signed [47:0]              prod_reg;
    logic [qpf_pkg::SQUARE_W-1:0]    sq_reg;
    logic [qpf_pkg::SQUARE_W-1:0]    old_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [qpf_pkg::SQUARE_W-1:0]    avg_reg;
    logic                            ov_reg;
    logic [SW-1:0]                   lpo_reg;
    logic [SW-1:0]                   hpo_reg;
    logic [SW-1:0]                   do_reg;
    logic [qpf_pkg::SQUARE_W-1:0]    sqo_reg;
    logic [qpf_pkg::SQUARE_W-1:0]    io_reg;

    logic                            m1_we;
    logic [qpf_pkg::HIST_AW-1:0]     m1_wa;
    logic [SW-1:0]                   m1_wd;
    logic [qpf_pkg::HIST_AW-1:0]     m1_ra;
    logic [SW-1:0]                   m1_rd;
    logic                            m2_we;
    logic [SQ_AW-1:0]                m2_wa;
    logic [qpf_pkg::SQUARE_W-1:0]    m2_wd;
    logic [SQ_AW-1:0]                m2_ra;
    logic [qpf_pkg::SQUARE_W-1:0]    m2_rd;

    qpf_pkg::div_ctl_t               dctl;
    logic [SUM_W-1:0]                dvd;
    logic                            div_done;
    logic [SUM_W-1:0]                quo;

    logic [7:0]                      div_eff;
    logic [6:0]                      wl_ext;
    logic [WIN_W-1:0]                win_eff;
    logic [WIN_W:0]                  old_t;
    logic [SQ_AW-1:0]                old_addr;
    logic [SQ_AW-1:0]                ptr_prev;
    logic [SQ_AW-1:0]                ptr_succ;
    logic [SQ_AW-1:0]                raddr_prev;
    logic signed [19:0]              term;
    logic [SW-1:0]                   src;
    logic [SW-1:0]                   mag;
    logic signed [24:0]              q_s;
    logic signed [27:0]              lp_sum;
    logic signed [27:0]              hp_sum;
    logic signed [27:0]              d_sum;
    logic signed [27:0]              d_trunc;
    logic [qpf_pkg::SQUARE_W-1:0]    sq_c;
    logic                            out_free;

    assign div_eff  = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
    assign wl_ext   = {1'b0, wlen_reg};

    always_comb
    begin
        if (wl_ext == 7'd0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (wl_ext > 7'(WINDOW_DEPTH))
        begin
            win_eff = WIN_W'(WINDOW_DEPTH);
        end
        else
        begin
            win_eff = wl_ext[WIN_W-1:0];
        end
    end

    assign old_t = ((WIN_W+1)'(ptr_reg) >= (WIN_W+1)'(win_eff))
                 ? (WIN_W+1)'(ptr_reg) - (WIN_W+1)'(win_eff)
                 : (WIN_W+1)'(ptr_reg) + (WIN_W+1)'(WINDOW_DEPTH) - (WIN_W+1)'(win_eff);
    assign old_addr   = old_t[SQ_AW-1:0];
    assign ptr_prev   = (ptr_reg == '0) ? SQ_AW'(WINDOW_DEPTH - 1) : ptr_reg - 1'b1;
    assign ptr_succ   = (ptr_reg == SQ_AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign raddr_prev = (raddr_reg == '0) ? SQ_AW'(WINDOW_DEPTH - 1) : raddr_reg - 1'b1;

    assign term = 20'(x0_reg) - (20'(x6_reg) <<< 1) + 20'(x12_reg);

    assign q_s    = neg_reg ? -$signed({1'b0, quo[SW-1:0]}) : $signed({1'b0, quo[SW-1:0]});
    assign lp_sum = (sx24(y1_reg) <<< 1) - sx24(y2_reg) + 28'(q_s);
    assign hp_sum = sx24(h1_reg) - 28'(q2_reg) + sx24(y16_reg) - sx24(y17_reg) + 28'(q_s);
    assign d_sum  = (sx24(hp_reg) <<< 1) + sx24(h1_reg) - sx24(h3_reg) - (sx24(h4_reg) <<< 1);
    assign d_trunc = (d_sum + (d_sum[27] ? 28'sd7 : 28'sd0)) >>> 3;
    assign sq_c   = (prod_reg[47:46] != 2'b00) ? {qpf_pkg::SQUARE_W{1'b1}}
                                               : prod_reg[45:0];
    assign out_free = !ov_reg || !out_stall;

    // history memory port selection
    always_comb
    begin
        m1_we = 1'b0;
        m1_wa = '0;
        m1_wd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                m1_we = 1'b1;
                m1_wa = clr_reg;
            end
            S_IDLE:
            begin
                m1_we = in_valid;
                m1_wa = {qpf_pkg::X_BASE, n_reg[qpf_pkg::X_AW-1:0]};
                m1_wd = SW'(sample);
            end
            S_LP:
            begin
                m1_we = 1'b1;
                m1_wa = {1'b0, n_reg};
                m1_wd = lp_reg;
            end
            default:
            begin
                m1_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            3'd0:    m1_ra = {qpf_pkg::X_BASE, n_reg[qpf_pkg::X_AW-1:0] - 4'd6};
            3'd1:    m1_ra = {qpf_pkg::X_BASE, n_reg[qpf_pkg::X_AW-1:0] - 4'd12};
            3'd2:    m1_ra = {1'b0, n_reg - 6'd1};
            3'd3:    m1_ra = {1'b0, n_reg - 6'd2};
            3'd4:    m1_ra = {1'b0, n_reg - 6'd16};
            3'd5:    m1_ra = {1'b0, n_reg - 6'd17};
            3'd6:    m1_ra = {1'b0, n_reg - 6'd32};
            default: m1_ra = '0;
        endcase
    end

    assign m2_we = (state_reg == S_ACC)
                || ((state_reg == S_CLEAR) && (8'(clr_reg) < 8'(WINDOW_DEPTH)));
    assign m2_wa = (state_reg == S_CLEAR) ? clr_reg[SQ_AW-1:0] : ptr_reg;
    assign m2_wd = (state_reg == S_CLEAR) ? '0 : sq_c;
    assign m2_ra = (state_reg == S_SUM) ? raddr_reg : old_addr;

    qpf_ram #(
        .WIDTH (SW),
        .DEPTH (qpf_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (m1_we),
        .waddr (m1_wa),
        .wdata (m1_wd),
        .raddr (m1_ra),
        .rdata (m1_rd)
    );

    qpf_ram #(
        .WIDTH (qpf_pkg::SQUARE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_sq_ram (
        .clk   (clk),
        .we    (m2_we),
        .waddr (m2_wa),
        .wdata (m2_wd),
        .raddr (m2_ra),
        .rdata (m2_rd)
    );

    // divider requests
    always_comb
    begin
        case (state_reg)
            S_READ:   src = SW'(term);
            S_LP:     src = lp_reg;
            default:  src = y32_reg;
        endcase
        mag = src[SW-1] ? -src : src;

        dctl.start   = 1'b0;
        dctl.iters   = qpf_pkg::DIV_CNT_W'(SW);
        dctl.divisor = div_eff;
        dvd          = {mag, {(SUM_W-SW){1'b0}}};
        case (state_reg)
            S_READ:   dctl.start = (cnt_reg == 3'd7);
            S_LP:     dctl.start = 1'b1;
            S_DIV_Y0: dctl.start = div_done;
            S_AVG_GO:
            begin
                dctl.start   = 1'b1;
                dctl.iters   = qpf_pkg::DIV_CNT_W'(SUM_W);
                dctl.divisor = 8'(win_eff);
                dvd          = sum_reg;
            end
            default:  dctl.start = 1'b0;
        endcase
    end

    qpf_div #(
        .DW (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (dvd),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (clr_reg == qpf_pkg::HIST_AW'(qpf_pkg::HIST_DEPTH - 1))
                           state_next = S_IDLE;
            S_IDLE:    if (in_valid) state_next = S_READ;
            S_READ:    if (cnt_reg == 3'd7) state_next = S_DIV_LP;
            S_DIV_LP:  if (div_done) state_next = S_LP;
            S_LP:      state_next = S_DIV_Y0;
            S_DIV_Y0:  if (div_done) state_next = S_DIV_Y32;
            S_DIV_Y32: if (div_done) state_next = S_DER;
            S_DER:     state_next = S_MUL;
            S_MUL:     state_next = S_ACC;
            S_ACC:     state_next = dirty_reg ? S_SUM : S_AVG_GO;
            S_SUM:     if ((rc_reg == '0) && !pend_reg) state_next = S_AVG_GO;
            S_AVG_GO:  state_next = S_AVG;
            S_AVG:     if (div_done) state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            ptr_reg     <= '0;
            rc_reg      <= '0;
            pend_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
            divisor_reg <= 8'd32;
            wlen_reg    <= 6'd30;
            sum_reg     <= '0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            h3_reg      <= '0;
            h4_reg      <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                if (cfg_index == qpf_pkg::REG_FILTER_DIVISOR)
                begin
                    divisor_reg <= cfg_data;
                end
                if (cfg_index == qpf_pkg::REG_WINDOW_LENGTH)
                begin
                    wlen_reg  <= cfg_data[5:0];
                    dirty_reg <= 1'b1;
                end
            end

            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (state_reg == S_READ)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (state_reg == S_DER)
            begin
                h1_reg <= hp_reg;
                h2_reg <= h1_reg;
                h3_reg <= h2_reg;
                h4_reg <= h3_reg;
            end

            if (state_reg == S_ACC)
            begin
                if (dirty_reg)
                begin
                    sum_reg <= SUM_W'(sq_c);
                    rc_reg  <= win_eff - 1'b1;
                end
                else
                begin
                    sum_reg <= sum_reg - SUM_W'(old_reg) + SUM_W'(sq_c);
                end
            end

            if (state_reg == S_SUM)
            begin
                pend_reg <= (rc_reg != '0);
                if (rc_reg != '0)
                begin
                    rc_reg <= rc_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(m2_rd);
                end
                if ((rc_reg == '0) && !pend_reg)
                begin
                    dirty_reg <= 1'b0;
                end
            end

            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                ov_reg  <= 1'b1;
                n_reg   <= n_reg + 1'b1;
                ptr_reg <= ptr_succ;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            x0_reg <= sample;
        end
        if (state_reg == S_READ)
        begin
            case (cnt_reg)
                3'd1:    x6_reg  <= m1_rd[15:0];
                3'd2:    x12_reg <= m1_rd[15:0];
                3'd3:    y1_reg  <= m1_rd;
                3'd4:    y2_reg  <= m1_rd;
                3'd5:    y16_reg <= m1_rd;
                3'd6:    y17_reg <= m1_rd;
                3'd7:    y32_reg <= m1_rd;
                default: y32_reg <= y32_reg;
            endcase
            if (cnt_reg == 3'd1)
            begin
                old_reg <= m2_rd;
            end
        end
        if (dctl.start)
        begin
            neg_reg <= src[SW-1];
        end
        if ((state_reg == S_DIV_LP) && div_done)
        begin
            lp_reg <= sat24(lp_sum);
        end
        if ((state_reg == S_DIV_Y0) && div_done)
        begin
            q2_reg <= q_s;
        end
        if ((state_reg == S_DIV_Y32) && div_done)
        begin
            hp_reg <= sat24(hp_sum);
        end
        if (state_reg == S_DER)
        begin
            d_reg <= sat24(d_trunc);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= d_reg * d_reg;
        end
        if (state_reg == S_ACC)
        begin
            sq_reg    <= sq_c;
            raddr_reg <= ptr_prev;
        end
        if ((state_reg == S_SUM) && (rc_reg != '0))
        begin
            raddr_reg <= raddr_prev;
        end
        if ((state_reg == S_AVG) && div_done)
        begin
            avg_reg <= quo[qpf_pkg::SQUARE_W-1:0];
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            lpo_reg <= lp_reg;
            hpo_reg <= hp_reg;
            do_reg  <= d_reg;
            sqo_reg <= sq_reg;
            io_reg  <= avg_reg;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ov_reg;
    assign lowpass_out    = lpo_reg;
    assign highpass_out   = hpo_reg;
    assign derivative_out = do_reg;
    assign squared_out    = sqo_reg;
    assign integrated_out = io_reg;

endmodule

[src/qpf_chk.sv]
// ----------------------------------------------------------------------------
// qpf_chk: port-level checks for the QRS preprocessing filter chain
// Watches handshakes and the consistency of the result word.
// ----------------------------------------------------------------------------
module qpf_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [qpf_pkg::STAGE_W-1:0]    derivative_out,
    input logic [qpf_pkg::SQUARE_W-1:0]          squared_out,
    input logic [qpf_pkg::SQUARE_W-1:0]          integrated_out
);

    logic signed [47:0]             dd;
    logic [qpf_pkg::SQUARE_W-1:0]   sq_exp;

    assign dd     = derivative_out * derivative_out;
    assign sq_exp = (dd[47:46] != 2'b00) ? {qpf_pkg::SQUARE_W{1'b1}} : dd[45:0];

    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(integrated_out))
        else $error("stalled result word changed");

    a_square_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> squared_out == sq_exp)
        else $error("square does not match derivative");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("input open during clearing pass");

endmodule

bind qrs_preprocess_filter_chain_core qpf_chk u_qpf_chk (.*);
